@@ rtl/ldrt_pkg.sv @@
// ----------------------------------------------------------------------------
// ldrt_pkg
// shared constants and the byte-to-symbol table of the longest distinct run
// tracker
// ----------------------------------------------------------------------------
package ldrt_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int MAX_LENGTH    = 65536;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 17;
    localparam int SYM_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int POS_W  = $clog2(MAX_LENGTH);
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

    localparam int BYTE_VALUES = 1 << BYTE_W;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // byte value modulo alphabet size, built by a running remainder
    function automatic sym_t [BYTE_VALUES-1:0] build_sym_table();
        sym_t [BYTE_VALUES-1:0] tbl;
        int                     r;
        r = 0;
        for (int i = 0; i < BYTE_VALUES; i++) begin
            tbl[i] = SYM_W'(r);
            r = (r + 1 == ALPHABET_SIZE) ? 0 : r + 1;
        end
        return tbl;
    endfunction

    localparam sym_t [BYTE_VALUES-1:0] SYM_TABLE = build_sym_table();

endpackage

@@ rtl/longest_distinct_run_tracker_core.sv @@
// ----------------------------------------------------------------------------
// longest_distinct_run_tracker_core
// longest repeat-free run of a byte string, one result beat per input beat
// ----------------------------------------------------------------------------
// Input beats carry one byte of a string; end_of_string marks its last byte.
// Each input beat yields one result beat with the longest repeat-free run so
// far in the string, the end mark echoed as is_final, and a saturation flag
// once the string runs past MAX_LENGTH bytes.
// Both channels use valid/ready. A result passes the compute stage register
// and then the output register before it appears on m_. One beat per cycle
// is sustained while the receiver keeps m_ready high: the last-position
// memory is read on accept and written as the beat leaves the compute stage;
// a one-entry forward path covers a write to the same entry at the read edge.
// When m_ready is low the output register holds its beat and one more beat
// can still enter the compute stage; after that s_ready drops until the
// receiver takes the waiting beat.
// Reset clears the per-byte valid flags and the run registers at once, with
// no clearing pass; the block accepts a beat right after reset. The same
// clear happens after every last byte of a string.
// ----------------------------------------------------------------------------
module longest_distinct_run_tracker_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ldrt_pkg::BYTE_W-1:0]   s_char_byte,
    input  logic                          s_end_of_string,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ldrt_pkg::LEN_W-1:0]    m_longest_length,
    output logic                          m_is_final,
    output logic                          m_length_saturated
);

    localparam ldrt_pkg::cnt_t MAX_CNT = ldrt_pkg::CNT_W'(ldrt_pkg::MAX_LENGTH);

    ldrt_pkg::pos_t pos_mem [ldrt_pkg::ALPHABET_SIZE];

    logic [ldrt_pkg::ALPHABET_SIZE-1:0] seen_reg, seen_next;

    logic            s1_valid_reg;
    ldrt_pkg::sym_t  s1_sym_reg;
    logic            s1_last_reg;
    ldrt_pkg::pos_t  rd_data_reg;
    logic            fwd_hit_reg;
    ldrt_pkg::pos_t  fwd_val_reg;

    ldrt_pkg::pos_t  window_reg, window_next;
    ldrt_pkg::cnt_t  count_reg, count_next;
    ldrt_pkg::cnt_t  best_reg, best_next;
    logic            sat_reg, sat_next;

    logic                        m_valid_reg;
    logic [ldrt_pkg::LEN_W-1:0]  m_len_reg;
    logic                        m_final_reg;
    logic                        m_sat_reg;

    logic            in_fire;
    logic            s1_adv;
    ldrt_pkg::sym_t  in_sym;
    logic            sat_cond;
    ldrt_pkg::pos_t  cur_pos;
    ldrt_pkg::pos_t  last_pos;
    logic            repeat_hit;
    ldrt_pkg::pos_t  ws_new;
    ldrt_pkg::cnt_t  run_len;
    ldrt_pkg::cnt_t  best_upd;
    logic            mem_we;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign in_fire = s_valid && s_ready;
    assign in_sym  = ldrt_pkg::SYM_TABLE[s_char_byte];

    // compute stage
    always_comb begin
        sat_cond   = (count_reg == MAX_CNT);
        cur_pos    = count_reg[ldrt_pkg::POS_W-1:0];
        last_pos   = fwd_hit_reg ? fwd_val_reg : rd_data_reg;
        repeat_hit = seen_reg[s1_sym_reg] && (last_pos >= window_reg);
        ws_new     = repeat_hit ? (last_pos + ldrt_pkg::POS_W'(1)) : window_reg;
        run_len    = ldrt_pkg::CNT_W'(cur_pos) - ldrt_pkg::CNT_W'(ws_new)
                     + ldrt_pkg::CNT_W'(1);
        best_upd   = (run_len > best_reg) ? run_len : best_reg;
        mem_we     = s1_adv && !sat_cond;

        seen_next   = seen_reg;
        window_next = window_reg;
        count_next  = count_reg;
        best_next   = best_reg;
        sat_next    = sat_reg;
        if (sat_cond) begin
            sat_next = 1'b1;
        end else begin
            seen_next[s1_sym_reg] = 1'b1;
            window_next = ws_new;
            count_next  = count_reg + ldrt_pkg::CNT_W'(1);
            best_next   = best_upd;
        end
    end

    // last-position memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pos_mem[s1_sym_reg] <= cur_pos;
        end
        if (in_fire) begin
            rd_data_reg <= pos_mem[in_sym];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_sym_reg  <= in_sym;
            s1_last_reg <= s_end_of_string;
            fwd_hit_reg <= mem_we && (s1_sym_reg == in_sym);
            fwd_val_reg <= cur_pos;
        end
        if (s1_adv) begin
            m_len_reg   <= ldrt_pkg::LEN_W'(best_next);
            m_final_reg <= s1_last_reg;
            m_sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            seen_reg     <= '0;
            window_reg   <= '0;
            count_reg    <= '0;
            best_reg     <= '0;
            sat_reg      <= 1'b0;
        end else begin
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                if (s1_last_reg) begin
                    seen_reg   <= '0;
                    window_reg <= '0;
                    count_reg  <= '0;
                    best_reg   <= '0;
                    sat_reg    <= 1'b0;
                end else begin
                    seen_reg   <= seen_next;
                    window_reg <= window_next;
                    count_reg  <= count_next;
                    best_reg   <= best_next;
                    sat_reg    <= sat_next;
                end
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_longest_length   = m_len_reg;
    assign m_is_final         = m_final_reg;
    assign m_length_saturated = m_sat_reg;

    // checks
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("position count above max length");

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ldrt_pkg::CNT_W'(window_reg) <= count_reg)
        else $error("window start past position count");

    a_best_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        best_reg <= count_reg)
        else $error("best length above position count");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_last_reg) |=> (count_reg == '0 && seen_reg == '0 && !sat_reg))
        else $error("string state not cleared after last byte");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the longest distinct run tracker core
// ----------------------------------------------------------------------------
// Strings of bytes go in on the s_ channel, one beat per byte, and the last
// byte of each string carries the end mark. A predictor tracks the last
// position of every byte value, the window start and the best run so far, and
// queues one expected result per accepted beat. Each result beat on m_ is
// compared field by field with the oldest queued entry. Directed strings
// cover repeats inside and outside the window and the byte extremes. A mid
// string pause lets every result drain. Random strings use narrow and full
// byte ranges and runs of all 256 values. Both sides idle at random, except
// during a stretch with no idling.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_BEATS = 780;

    typedef struct packed {
        logic [ldrt_pkg::LEN_W-1:0] longest_length;
        logic                       is_final;
        logic                       length_saturated;
    } run_result_t;

    logic                         aclk               = 1'b0;
    logic                         aresetn            = 1'b0;
    logic                         s_valid            = 1'b0;
    logic                         s_ready;
    logic [ldrt_pkg::BYTE_W-1:0]  s_char_byte        = '0;
    logic                         s_end_of_string    = 1'b0;
    logic                         m_valid;
    logic                         m_ready            = 1'b0;
    logic [ldrt_pkg::LEN_W-1:0]   m_longest_length;
    logic                         m_is_final;
    logic                         m_length_saturated;

    run_result_t        expected_runs[$];
    int                 err_cnt            = 0;
    int                 cycle_cnt          = 0;
    bit                 src_idle_en        = 1'b1;
    bit                 sink_idle_en       = 1'b1;

    // predictor state
    logic                         seen_tbl     [ldrt_pkg::ALPHABET_SIZE];
    ldrt_pkg::pos_t               last_pos_tbl [ldrt_pkg::ALPHABET_SIZE];
    ldrt_pkg::cnt_t               win_start;
    ldrt_pkg::cnt_t               pos_cnt;
    logic [ldrt_pkg::LEN_W-1:0]   best_len;
    logic                         sat_seen;

    longest_distinct_run_tracker_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_byte        (s_char_byte),
        .s_end_of_string    (s_end_of_string),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_longest_length   (m_longest_length),
        .m_is_final         (m_is_final),
        .m_length_saturated (m_length_saturated)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void clear_run_state();
        for (int i = 0; i < ldrt_pkg::ALPHABET_SIZE; i++) begin
            seen_tbl[i]     = 1'b0;
            last_pos_tbl[i] = '0;
        end
        win_start = '0;
        pos_cnt   = '0;
        best_len  = '0;
        sat_seen  = 1'b0;
    endfunction

    function automatic run_result_t predict_run(input logic [ldrt_pkg::BYTE_W-1:0] c,
                                                input logic eos);
        ldrt_pkg::sym_t  sym;
        ldrt_pkg::cnt_t  run;
        run_result_t     r;
        sym = ldrt_pkg::sym_t'(int'(c) % ldrt_pkg::ALPHABET_SIZE);
        if (pos_cnt >= ldrt_pkg::cnt_t'(ldrt_pkg::MAX_LENGTH)) begin
            sat_seen = 1'b1;
        end else begin
            // repeat inside the window moves the start past the earlier copy
            if (seen_tbl[sym] && ldrt_pkg::cnt_t'(last_pos_tbl[sym]) >= win_start) begin
                win_start = ldrt_pkg::cnt_t'(last_pos_tbl[sym]) + ldrt_pkg::cnt_t'(1);
            end
            last_pos_tbl[sym] = ldrt_pkg::pos_t'(pos_cnt);
            seen_tbl[sym]     = 1'b1;
            run = pos_cnt - win_start + ldrt_pkg::cnt_t'(1);
            if (ldrt_pkg::LEN_W'(run) > best_len) begin
                best_len = ldrt_pkg::LEN_W'(run);
            end
            pos_cnt = pos_cnt + ldrt_pkg::cnt_t'(1);
        end
        r.longest_length   = best_len;
        r.is_final         = eos;
        r.length_saturated = sat_seen;
        if (eos) begin
            clear_run_state();
        end
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_char(input logic [ldrt_pkg::BYTE_W-1:0] c, input logic eos);
        while (src_idle_en && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_char_byte     <= c;
        s_end_of_string <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_runs.push_back(predict_run(c, eos));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_runs.size() != 0);
    endtask

    always @(negedge aclk) begin
        m_ready <= sink_idle_en ? ($urandom_range(0, 99) >= 24) : 1'b1;
    end

    always @(posedge aclk) begin : result_check
        run_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_runs.size() == 0) begin
                $error("result beat with none expected, longest_length %0d",
                       m_longest_length);
                err_cnt++;
            end else begin
                want = expected_runs.pop_front();
                if (m_longest_length !== want.longest_length) begin
                    $error("longest_length expected %0d actual %0d",
                           want.longest_length, m_longest_length);
                    err_cnt++;
                end
                if (m_is_final !== want.is_final) begin
                    $error("is_final expected %0b actual %0b", want.is_final, m_is_final);
                    err_cnt++;
                end
                if (m_length_saturated !== want.length_saturated) begin
                    $error("length_saturated expected %0b actual %0b",
                           want.length_saturated, m_length_saturated);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [ldrt_pkg::BYTE_W-1:0] abc [8] = '{8'h61, 8'h62, 8'h63, 8'h61,
                                                 8'h62, 8'h63, 8'h62, 8'h62};
        logic [ldrt_pkg::BYTE_W-1:0] pww [6] = '{8'h70, 8'h77, 8'h77, 8'h6b, 8'h65, 8'h77};
        logic [ldrt_pkg::BYTE_W-1:0] abba[4] = '{8'h61, 8'h62, 8'h62, 8'h61};
        logic [ldrt_pkg::BYTE_W-1:0] ext [5] = '{8'hff, 8'h00, 8'hff, 8'h7f, 8'h80};
        send_char(8'h00, 1'b1);
        foreach (abc[i]) send_char(abc[i], i == 7);
        // stale copy before the window start must not move it back
        foreach (abba[i]) send_char(abba[i], i == 3);
        foreach (pww[i]) send_char(pww[i], i == 5);
        foreach (ext[i]) send_char(ext[i], i == 4);
    endtask

    task automatic test_pause_drain();
        int len;
        for (int s = 0; s < 3; s++) begin
            len = $urandom_range(6, 20);
            for (int i = 0; i < len; i++) begin
                send_char(8'h40 + 8'($urandom_range(0, 5)), i == len - 1);
                if (i == len / 2) drain_results();
            end
        end
        drain_results();
    endtask

    task automatic test_random_strings();
        int                           n_beats;
        int                           kind;
        int                           len;
        int                           span;
        logic [ldrt_pkg::BYTE_W-1:0]  base;
        logic [ldrt_pkg::BYTE_W-1:0]  c;
        n_beats = 0;
        while (n_beats < RANDOM_BEATS) begin
            src_idle_en  = !(n_beats >= 300 && n_beats < 420);
            sink_idle_en = src_idle_en;
            kind = $urandom_range(0, 99);
            base = 8'($urandom);
            span = $urandom_range(1, 8);
            if (kind < 55)      len = $urandom_range(1, 40);
            else if (kind < 85) len = $urandom_range(1, 64);
            else if (kind < 93) len = $urandom_range(250, 270);
            else                len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
                if (kind < 55)      c = base + 8'($urandom_range(0, span - 1));
                else if (kind < 85) c = 8'($urandom);
                else if (kind < 93) c = base + 8'(i);
                else                c = base;
                send_char(c, i == len - 1);
            end
            n_beats += len;
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        clear_run_state();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_pause_drain();
        test_random_strings();
        drain_results();
        repeat (8) @(negedge aclk);
        if (err_cnt == 0 && expected_runs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
